// ===== rtl/pcta_pkg.sv =====
// shared types, codes and sizes of the pwm channel and timer allocator
package pcta_pkg;

   localparam int CHANNELS     = 8;
   localparam int TIMERS       = 4;
   localparam int MAX_RES_BITS = 14;
   localparam int RES_LIMIT    = 31;
   localparam int DUTY_W       = 20;
   localparam int LMAX_W       = 32;
   localparam int NUM_W        = LMAX_W + DUTY_W;
   localparam int CH_IW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TM_IW        = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int REF_W        = $clog2(CHANNELS + 1);
   localparam int DCNT_W       = $clog2(DUTY_W + 1);

   typedef enum logic [1:0] {
      ACT_ACQUIRE = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_STOP    = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ARG  = 3'd1,
      ST_BUSY     = 3'd2,
      ST_NO_TIMER = 3'd3,
      ST_BAD_HDL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE          = 3'd0,
      CMD_CONFIGURE     = 3'd1,
      CMD_UPDATE        = 3'd2,
      CMD_STOP_HIGH     = 3'd3,
      CMD_CFG_STOP_HIGH = 3'd4,
      CMD_STOP_LOW      = 3'd5,
      CMD_STOP_DECONFIG = 3'd6
   } command_type;

   typedef struct packed {
      action_type   action;
      logic [5:0]   pin;
      logic [25:0]  freq;
      logic [31:0]  full_scale;
      logic [4:0]   allowed_bits;
      logic [2:0]   handle;
      logic [31:0]  level;
      logic [4:0]   res;
      logic         bad;
   } item_type;

   typedef struct packed {
      status_type          status;
      logic [2:0]          chan;
      logic [1:0]          tmr;
      logic [4:0]          resolution;
      logic                timer_setup;
      logic                timer_freed;
      command_type         command;
      logic [DUTY_W-1:0]   duty;
   } result_type;

endpackage

// ===== rtl/pcta_front.sv =====
// front end: accepts items, checks acquire arguments, works out resolution, queues items
module pcta_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          action,
   input  logic [5:0]          pin,
   input  logic [25:0]         freq,
   input  logic [31:0]         full_scale,
   input  logic [4:0]          allowed_bits,
   input  logic [2:0]          handle,
   input  logic [31:0]         level,
   output logic                q_valid,
   output pcta_pkg::item_type  q_item,
   input  logic                q_pop
);
   import pcta_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item_c;
   logic [5:0] nb;
   logic [4:0] maxb;
   logic       acc;

   // bit length of the logical maximum, limited to one through thirty-one
   always_comb begin
      nb = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (full_scale[i]) begin
            nb = 6'(i + 1);
         end
      end
      if (nb == 6'd0) begin
         nb = 6'd1;
      end
      if (nb > 6'(RES_LIMIT)) begin
         nb = 6'(RES_LIMIT);
      end
      maxb = (allowed_bits > 5'(MAX_RES_BITS)) ? 5'(MAX_RES_BITS) : allowed_bits;
      item_c.action        = action_type'(action);
      item_c.pin           = pin;
      item_c.freq          = freq;
      item_c.full_scale    = full_scale;
      item_c.allowed_bits  = allowed_bits;
      item_c.handle        = handle;
      item_c.level         = level;
      item_c.res           = (nb > {1'b0, maxb}) ? maxb : nb[4:0];
      item_c.bad           = (freq == 26'd0) || (full_scale == 32'd0)
                             || (allowed_bits == 5'd0);
   end

   assign full    = (cnt_ff == 2'd2);
   assign acc     = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ acc;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      cnt_in    = cnt_ff + 2'(acc) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         q_ff[wr_ptr_ff] <= item_c;
      end
   end

endmodule

// ===== rtl/pcta_div.sv =====
// restoring divider for the duty scaling, one quotient bit per cycle
module pcta_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pcta_pkg::NUM_W-1:0]   num,
   input  logic [pcta_pkg::LMAX_W-1:0]  den,
   output logic                         done,
   output logic [pcta_pkg::DUTY_W-1:0]  quo
);
   import pcta_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [LMAX_W-1:0]   rem_ff, rem_in;
   logic [DUTY_W-1:0]   lo_ff, lo_in;
   logic [DUTY_W-1:0]   quo_ff, quo_in;
   logic [LMAX_W-1:0]   den_ff;
   logic [LMAX_W:0]     trial;
   logic                ge;

   // quotient fits in the duty width, so the upper bits start as the remainder
   always_comb begin
      trial   = {rem_ff, lo_ff[DUTY_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DUTY_W);
         rem_in  = num[NUM_W-1:DUTY_W];
         lo_in   = num[DUTY_W-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? LMAX_W'(trial - {1'b0, den_ff}) : trial[LMAX_W-1:0];
         lo_in  = {lo_ff[DUTY_W-2:0], 1'b0};
         quo_in = {quo_ff[DUTY_W-2:0], ge};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/pcta_back.sv =====
// back end: channel and timer tables, command decisions, duty scaling and result register
module pcta_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  pcta_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output pcta_pkg::result_type rsp,
   input  logic                 rsp_take
);
   import pcta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_START = 4'b0100,
      S_DIV   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   item_type          item_ff;
   result_type        rsp_ff;
   logic              rsp_valid_ff;
   logic [NUM_W-1:0]  prod_ff;

   logic              ch_used_ff [CHANNELS];
   logic              ch_cfg_ff  [CHANNELS];
   logic              ch_full_ff [CHANNELS];
   logic [5:0]        ch_pin_ff  [CHANNELS];
   logic [TM_IW-1:0]  ch_tmr_ff  [CHANNELS];
   logic [4:0]        ch_res_ff  [CHANNELS];
   logic [31:0]       ch_lmax_ff [CHANNELS];
   logic              tm_used_ff [TIMERS];
   logic [REF_W-1:0]  tm_refs_ff [TIMERS];
   logic [4:0]        tm_res_ff  [TIMERS];
   logic [25:0]       tm_freq_ff [TIMERS];

   logic              pin_busy, free_found, tm_found;
   logic [CH_IW-1:0]  ci;
   logic [TM_IW-1:0]  ti;
   logic [4:0]        h_ext;
   logic              h_ok;
   logic [CH_IW-1:0]  hi;
   logic              full, fresh, need_div;
   command_type       wcmd;
   logic [TM_IW-1:0]  rt;
   logic [REF_W-1:0]  refs_dec;
   logic [DUTY_W-1:0] hw;
   logic [NUM_W-1:0]  prod_c;
   result_type        rsp_c;
   logic              div_done;
   logic [DUTY_W-1:0] div_quo;

   // lookups over the tables, lowest index wins
   always_comb begin
      pin_busy   = 1'b0;
      free_found = 1'b0;
      ci         = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (ch_used_ff[i] && (ch_pin_ff[i] == item_ff.pin)) begin
            pin_busy = 1'b1;
         end
         if (!ch_used_ff[i]) begin
            free_found = 1'b1;
            ci         = CH_IW'(i);
         end
      end
      tm_found = 1'b0;
      ti       = '0;
      for (int i = TIMERS - 1; i >= 0; i--) begin
         if (tm_used_ff[i] && (tm_freq_ff[i] == item_ff.freq)
             && (tm_res_ff[i] == item_ff.res)) begin
            tm_found = 1'b1;
            ti       = TM_IW'(i);
         end
      end
      if (!tm_found) begin
         for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!tm_used_ff[i]) begin
               tm_found = 1'b1;
               ti       = TM_IW'(i);
            end
         end
      end
   end

   always_comb begin
      h_ext    = {2'b00, item_ff.handle};
      hi       = h_ext[CH_IW-1:0];
      h_ok     = (h_ext < 5'(CHANNELS)) && ch_used_ff[hi];
      full     = (item_ff.level >= ch_lmax_ff[hi]);
      fresh    = !ch_cfg_ff[hi];
      wcmd     = fresh ? CMD_CONFIGURE : CMD_NONE;
      if (full && !ch_full_ff[hi]) begin
         wcmd = fresh ? CMD_CFG_STOP_HIGH : CMD_STOP_HIGH;
      end else if (!full && !fresh) begin
         wcmd = CMD_UPDATE;
      end
      rt       = ch_tmr_ff[hi];
      refs_dec = (tm_refs_ff[rt] != '0) ? tm_refs_ff[rt] - REF_W'(1) : '0;
      hw       = DUTY_W'((21'(1) << ch_res_ff[hi]) - 21'(1));
      prod_c   = NUM_W'(item_ff.level) * NUM_W'(hw) + NUM_W'(ch_lmax_ff[hi] >> 1);
      need_div = (item_ff.action == ACT_WRITE) && h_ok && !full;

      rsp_c               = '0;
      rsp_c.status        = ST_OK;
      rsp_c.command       = CMD_NONE;
      rsp_c.chan          = item_ff.handle;
      unique case (item_ff.action)
         ACT_ACQUIRE: begin
            rsp_c.chan = 3'(ci);
            if (item_ff.bad) begin
               rsp_c.status = ST_BAD_ARG;
            end else if (pin_busy || !free_found) begin
               rsp_c.status = ST_BUSY;
            end else if (!tm_found) begin
               rsp_c.status = ST_NO_TIMER;
            end else begin
               rsp_c.tmr         = 2'(ti);
               rsp_c.resolution  = item_ff.res;
               rsp_c.timer_setup = !tm_used_ff[ti];
            end
            if (rsp_c.status != ST_OK) begin
               rsp_c.chan = 3'd0;
            end
         end
         ACT_WRITE, ACT_STOP, ACT_RELEASE: begin
            if (!h_ok) begin
               rsp_c.status = ST_BAD_HDL;
            end else begin
               rsp_c.tmr         = 2'(ch_tmr_ff[hi]);
               rsp_c.resolution  = ch_res_ff[hi];
               if (item_ff.action == ACT_WRITE) begin
                  rsp_c.command = wcmd;
               end else if (item_ff.action == ACT_STOP) begin
                  rsp_c.command = ch_cfg_ff[hi] ? CMD_STOP_LOW : CMD_NONE;
               end else begin
                  rsp_c.command     = ch_cfg_ff[hi] ? CMD_STOP_DECONFIG : CMD_NONE;
                  rsp_c.timer_freed = (refs_dec == '0);
               end
            end
         end
         default: ;
      endcase
   end

   assign q_pop = (state_ff == S_IDLE) && q_valid && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (q_pop) state_in = S_EXEC;
         S_EXEC:  state_in = need_div ? S_START : S_IDLE;
         S_START: state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   pcta_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_START),
      .num   (prod_ff),
      .den   (ch_lmax_ff[hi]),
      .done  (div_done),
      .quo   (div_quo)
   );

   // control state of the tables and the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            ch_used_ff[i] <= 1'b0;
            ch_cfg_ff[i]  <= 1'b0;
            ch_full_ff[i] <= 1'b0;
         end
         for (int i = 0; i < TIMERS; i++) begin
            tm_used_ff[i] <= 1'b0;
            tm_refs_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_take && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == S_EXEC) && !need_div) begin
            rsp_valid_ff <= 1'b1;
         end
         if ((state_ff == S_DIV) && div_done) begin
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == S_EXEC) begin
            unique case (item_ff.action)
               ACT_ACQUIRE: begin
                  if (rsp_c.status == ST_OK) begin
                     ch_used_ff[ci] <= 1'b1;
                     ch_cfg_ff[ci]  <= 1'b0;
                     ch_full_ff[ci] <= 1'b0;
                     tm_used_ff[ti] <= 1'b1;
                     tm_refs_ff[ti] <= tm_used_ff[ti] ? tm_refs_ff[ti] + REF_W'(1)
                                                      : REF_W'(1);
                  end
               end
               ACT_WRITE: begin
                  if (h_ok) begin
                     ch_cfg_ff[hi]  <= 1'b1;
                     ch_full_ff[hi] <= full;
                  end
               end
               ACT_STOP: begin
                  if (h_ok && ch_cfg_ff[hi]) begin
                     ch_full_ff[hi] <= 1'b0;
                  end
               end
               ACT_RELEASE: begin
                  if (h_ok) begin
                     ch_used_ff[hi] <= 1'b0;
                     ch_cfg_ff[hi]  <= 1'b0;
                     ch_full_ff[hi] <= 1'b0;
                     tm_refs_ff[rt] <= refs_dec;
                     if (refs_dec == '0) begin
                        tm_used_ff[rt] <= 1'b0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // payload of the tables, read only behind an in-use flag
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == S_EXEC) begin
         rsp_ff  <= rsp_c;
         prod_ff <= prod_c;
         if ((item_ff.action == ACT_ACQUIRE) && (rsp_c.status == ST_OK)) begin
            ch_pin_ff[ci]  <= item_ff.pin;
            ch_tmr_ff[ci]  <= ti;
            ch_res_ff[ci]  <= item_ff.res;
            ch_lmax_ff[ci] <= item_ff.full_scale;
            if (!tm_used_ff[ti]) begin
               tm_res_ff[ti]  <= item_ff.res;
               tm_freq_ff[ti] <= item_ff.freq;
            end
         end
      end
      if ((state_ff == S_DIV) && div_done) begin
         rsp_ff.duty <= div_quo;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   logic [TIMERS-1:0]   tm_mismatch;
   logic [CHANNELS-1:0] ch_orphan;
   always_comb begin
      for (int i = 0; i < TIMERS; i++) begin
         tm_mismatch[i] = tm_used_ff[i] != (tm_refs_ff[i] != '0);
      end
      for (int i = 0; i < CHANNELS; i++) begin
         ch_orphan[i] = ch_used_ff[i] && !tm_used_ff[ch_tmr_ff[i]];
      end
   end

   a_refs_match: assert property (@(posedge clock) disable iff (reset)
      tm_mismatch == '0) else $error("timer in-use flag and count disagree");
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      ch_orphan == '0) else $error("channel bound to a free timer");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid_ff && (state_ff == S_IDLE)) else $error("pop while busy");
   a_div_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && div_done |=> rsp_valid_ff) else $error("duty lost");
`endif

endmodule

// ===== rtl/pwm_channel_timer_allocator_core.sv =====
// top level of the pwm channel and timer allocator
// Items enter through a two-entry queue (push/full) and results leave from a one-item
// register (empty/pop). Each item gets exactly one result, in order. Acquire, stop,
// release, full-scale write and invalid-handle items take their result from the execute
// state; a write that needs scaling takes it from the 20-step divider that forms the
// rounded duty (value * (2^res - 1) + max/2) / max. The back end works on one item at a
// time and takes the next one the cycle after the previous result has been popped, while
// the front queue keeps taking items until both of its entries are filled. No clearing
// pass is needed after reset.
module pwm_channel_timer_allocator_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [1:0]   req_action,
   input  logic [5:0]   req_pin,
   input  logic [25:0]  req_freq,
   input  logic [31:0]  req_full_scale,
   input  logic [4:0]   req_allowed_bits,
   input  logic [2:0]   req_handle,
   input  logic [31:0]  req_level,
   output logic         empty,
   input  logic         pop,
   output logic [2:0]   rsp_status,
   output logic [2:0]   rsp_chan,
   output logic [1:0]   rsp_tmr,
   output logic [4:0]   rsp_resolution,
   output logic         rsp_timer_setup,
   output logic         rsp_timer_freed,
   output logic [2:0]   rsp_command,
   output logic [19:0]  rsp_duty
);
   import pcta_pkg::*;

   logic       q_valid;
   item_type   q_item;
   logic       q_pop;
   logic       rsp_valid;
   result_type rsp;

   // front: argument checks and resolution, queued toward the back end
   pcta_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .action        (req_action),
      .pin           (req_pin),
      .freq          (req_freq),
      .full_scale    (req_full_scale),
      .allowed_bits  (req_allowed_bits),
      .handle        (req_handle),
      .level         (req_level),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // back: tables, command choice, duty divider, result register
   pcta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_take  (pop)
   );

   // result ports straight from the result register
   assign empty             = !rsp_valid;
   assign rsp_status        = rsp.status;
   assign rsp_chan          = rsp.chan;
   assign rsp_tmr           = rsp.tmr;
   assign rsp_resolution    = rsp.resolution;
   assign rsp_timer_setup   = rsp.timer_setup;
   assign rsp_timer_freed   = rsp.timer_freed;
   assign rsp_command       = rsp.command;
   assign rsp_duty          = rsp.duty;

endmodule

// ===== sim/pwm_channel_timer_allocator_core_tb.sv =====
// self-checking testbench of the pwm channel and timer allocator core
`timescale 1ns / 1ps

module pwm_channel_timer_allocator_core_tb;
   import pcta_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_action = '0;
   logic [5:0]  req_pin = '0;
   logic [25:0] req_freq = '0;
   logic [31:0] req_full_scale = '0;
   logic [4:0]  req_allowed_bits = '0;
   logic [2:0]  req_handle = '0;
   logic [31:0] req_level = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_chan;
   logic [1:0]  rsp_tmr;
   logic [4:0]  rsp_resolution;
   logic        rsp_timer_setup;
   logic        rsp_timer_freed;
   logic [2:0]  rsp_command;
   logic [19:0] rsp_duty;

   pwm_channel_timer_allocator_core dut (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator state mirrored by the predictor
   typedef struct {
      bit          used;
      bit          cfg;
      bit          high;
      logic [5:0]  pin;
      logic [1:0]  tmr;
      logic [4:0]  res;
      logic [31:0] lmax;
   } chan_rec;

   typedef struct {
      bit          used;
      int unsigned refs;
      logic [4:0]  res;
      logic [25:0] freq;
   } tmr_rec;

   typedef struct {
      action_type  act;
      logic [5:0]  pin;
      logic [25:0] freq;
      logic [31:0] lmax;
      logic [4:0]  abits;
      logic [2:0]  hdl;
      logic [31:0] val;
   } req_rec;

   chan_rec    chans[CHANNELS];
   tmr_rec     tmrs[TIMERS];
   result_type pending_results[$];
   int         errors = 0;
   int         results_seen = 0;
   int         items_sent = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   bit         rx_hold = 1'b0;
   bit         hold_req = 1'b0;

   function automatic result_type blank(status_type s, logic [2:0] ch);
      result_type r;
      r = '0;
      r.status = s;
      r.chan = ch;
      r.command = CMD_NONE;
      return r;
   endfunction

   // rounded, clamped duty scaling
   function automatic logic [19:0] duty_of(logic [31:0] v, logic [31:0] lmax,
                                           logic [4:0] res);
      logic [63:0] hw;
      logic [63:0] vv;
      vv = (v > lmax) ? lmax : v;
      hw = (64'd1 << res) - 64'd1;
      return 20'((vv * hw + lmax / 2) / lmax);
   endfunction

   function automatic result_type predict_allocation(req_rec q);
      result_type r;
      logic [4:0] res;
      logic [4:0] maxb;
      int         ci;
      int         ti;
      bit         busy;
      bit         is_full;
      chan_rec    c;
      ci = -1;
      ti = -1;
      busy = 1'b0;
      r = blank(ST_OK, '0);
      if (q.act == ACT_ACQUIRE) begin
         if (q.freq == 0 || q.lmax == 0 || q.abits == 0) return blank(ST_BAD_ARG, '0);
         maxb = (q.abits > MAX_RES_BITS) ? 5'(MAX_RES_BITS) : q.abits;
         res = 5'd1;
         while (res < 31 && ((64'd1 << res) - 64'd1) < {32'd0, q.lmax}) res++;
         if (res > maxb) res = maxb;
         foreach (chans[i]) if (chans[i].used && chans[i].pin == q.pin) busy = 1'b1;
         if (!busy)
            for (int i = CHANNELS - 1; i >= 0; i--) if (!chans[i].used) ci = i;
         for (int i = TIMERS - 1; i >= 0; i--)
            if (tmrs[i].used && tmrs[i].freq == q.freq && tmrs[i].res == res) ti = i;
         if (ti < 0)
            for (int i = TIMERS - 1; i >= 0; i--) if (!tmrs[i].used) ti = i;
         if (ci < 0) return blank(ST_BUSY, '0);
         if (ti < 0) return blank(ST_NO_TIMER, '0);
         if (!tmrs[ti].used) begin
            tmrs[ti] = '{used: 1'b1, refs: 0, res: res, freq: q.freq};
            r.timer_setup = 1'b1;
         end
         tmrs[ti].refs++;
         chans[ci] = '{used: 1'b1, cfg: 1'b0, high: 1'b0, pin: q.pin, tmr: 2'(ti),
                       res: res, lmax: q.lmax};
         r.chan = 3'(ci);
         r.tmr = 2'(ti);
         r.resolution = res;
         return r;
      end
      if (!chans[q.hdl].used) return blank(ST_BAD_HDL, q.hdl);
      c = chans[q.hdl];
      r.chan = q.hdl;
      r.tmr = c.tmr;
      r.resolution = c.res;
      case (q.act)
         ACT_WRITE: begin
            is_full = q.val >= c.lmax;
            r.duty = is_full ? 20'd0 : duty_of(q.val, c.lmax, c.res);
            if (!c.cfg) r.command = CMD_CONFIGURE;
            if (is_full && !c.high) r.command = c.cfg ? CMD_STOP_HIGH : CMD_CFG_STOP_HIGH;
            else if (!is_full && c.cfg) r.command = CMD_UPDATE;
            chans[q.hdl].cfg = 1'b1;
            chans[q.hdl].high = is_full;
         end
         ACT_STOP: begin
            if (c.cfg) begin
               r.command = CMD_STOP_LOW;
               chans[q.hdl].high = 1'b0;
            end
         end
         default: begin
            if (c.cfg) r.command = CMD_STOP_DECONFIG;
            if (tmrs[c.tmr].refs > 0) tmrs[c.tmr].refs--;
            if (tmrs[c.tmr].refs == 0) begin
               tmrs[c.tmr] = '{used: 1'b0, refs: 0, res: '0, freq: '0};
               r.timer_freed = 1'b1;
            end
            chans[q.hdl] = '{used: 1'b0, cfg: 1'b0, high: 1'b0, pin: '0, tmr: '0,
                             res: '0, lmax: '0};
         end
      endcase
      return r;
   endfunction

   // offer one item, with random idle cycles before it, and predict its result
   task automatic send_item(req_rec q, bit check_given, result_type given);
      result_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_action <= q.act;
      req_pin <= q.pin;
      req_freq <= q.freq;
      req_full_scale <= q.lmax;
      req_allowed_bits <= q.abits;
      req_handle <= q.hdl;
      req_level <= q.val;
      @(posedge clock);
      while (full) @(posedge clock);
      r = predict_allocation(q);
      if (check_given && r != given) begin
         $display("%0t directed row %0d: table says %p, predictor says %p",
                  $time, items_sent, given, r);
         errors++;
      end
      pending_results.push_back(r);
      items_sent++;
   endtask

   // result side: compare each popped item with the oldest prediction
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && pop && !empty) begin
         got = '{status_type'(rsp_status), rsp_chan, rsp_tmr,
                 rsp_resolution, rsp_timer_setup, rsp_timer_freed,
                 command_type'(rsp_command), rsp_duty};
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result %p", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) begin
               $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.chan != want.chan) begin
               $display("%0t chan: expected %0d actual %0d", $time,
                        want.chan, got.chan);
               errors++;
            end
            if (got.tmr != want.tmr) begin
               $display("%0t tmr: expected %0d actual %0d", $time,
                        want.tmr, got.tmr);
               errors++;
            end
            if (got.resolution != want.resolution) begin
               $display("%0t resolution: expected %0d actual %0d", $time,
                        want.resolution, got.resolution);
               errors++;
            end
            if (got.timer_setup != want.timer_setup) begin
               $display("%0t timer_setup: expected %0d actual %0d", $time,
                        want.timer_setup, got.timer_setup);
               errors++;
            end
            if (got.timer_freed != want.timer_freed) begin
               $display("%0t timer_freed: expected %0d actual %0d", $time,
                        want.timer_freed, got.timer_freed);
               errors++;
            end
            if (got.command != want.command) begin
               $display("%0t command: expected %0d actual %0d", $time,
                        want.command, got.command);
               errors++;
            end
            if (got.duty != want.duty) begin
               $display("%0t duty: expected %0d actual %0d", $time, want.duty, got.duty);
               errors++;
            end
         end
      end
   end

   // pop driver: random stalls, or a long hold-off while rx_hold is set
   always @(posedge clock) begin
      if (reset || rx_hold) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   // long receiver hold-off, counted in cycles, once the sender asks for it
   initial begin
      wait (hold_req);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // directed table: action, pin, freq, lmax, allowed, handle, value; check flag and result
   typedef struct {
      req_rec     q;
      bit         chk;
      result_type r;
   } row_rec;

   function automatic row_rec mk(action_type a, logic [5:0] p, logic [25:0] f,
                                 logic [31:0] m, logic [4:0] b, logic [2:0] h,
                                 logic [31:0] v, bit chk, result_type r);
      row_rec x;
      x.q = '{act: a, pin: p, freq: f, lmax: m, abits: b, hdl: h, val: v};
      x.chk = chk;
      x.r = r;
      return x;
   endfunction

   function automatic req_rec random_req(bit sane);
      req_rec q;
      int k;
      q.act = action_type'($urandom_range(3));
      q.pin = sane ? 6'($urandom_range(11)) : 6'($urandom);
      k = $urandom_range(3);
      q.freq = (k == 0) ? 26'($urandom) : (k == 1) ? 26'd40000000 : 26'(1000 * (1 + $urandom_range(2)));
      k = $urandom_range(5);
      case (k)
         0: q.lmax = $urandom;
         1: q.lmax = 32'hFFFF_FFFF;
         2: q.lmax = 32'd1 + $urandom_range(3);
         default: q.lmax = 32'd1 << $urandom_range(31);
      endcase
      q.abits = sane ? 5'($urandom_range(31, 1)) : 5'($urandom);
      if (!sane && $urandom_range(3) == 0) begin
         if ($urandom_range(1)) q.freq = '0; else q.lmax = '0;
      end
      q.hdl = 3'($urandom);
      k = $urandom_range(4);
      q.val = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'd0 :
              (k == 2) ? q.lmax : 32'(64'($urandom) % (64'(q.lmax) + 64'd1));
      if (sane && $urandom_range(1)) q.act = ($urandom_range(2) == 0) ? ACT_ACQUIRE : ACT_WRITE;
      return q;
   endfunction

   initial begin
      row_rec     rows[$];
      result_type z;
      int         phase;
      int         wait_count;
      z = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // invalid handle after reset, bad arguments, busy pin, grants, writes, stops, no free timer and releases
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 7, 0, 1, blank(ST_BAD_HDL, 3'd7)));
      rows.push_back(mk(ACT_STOP, 0, 0, 0, 0, 0, 0, 1, blank(ST_BAD_HDL, 3'd0)));
      rows.push_back(mk(ACT_RELEASE, 0, 0, 0, 0, 3, 0, 1, blank(ST_BAD_HDL, 3'd3)));
      rows.push_back(mk(ACT_ACQUIRE, 1, 0, 255, 8, 0, 0, 1, blank(ST_BAD_ARG, '0)));
      rows.push_back(mk(ACT_ACQUIRE, 1, 1000, 0, 8, 0, 0, 1, blank(ST_BAD_ARG, '0)));
      rows.push_back(mk(ACT_ACQUIRE, 1, 1000, 255, 0, 0, 0, 1, blank(ST_BAD_ARG, '0)));
      rows.push_back(mk(ACT_ACQUIRE, 0, 1000, 255, 31, 0, 0, 0, z));
      rows.push_back(mk(ACT_ACQUIRE, 0, 1000, 255, 31, 0, 0, 1, blank(ST_BUSY, '0)));
      rows.push_back(mk(ACT_ACQUIRE, 63, 26'h3FFFFFF, 32'hFFFFFFFF, 31, 0, 0, 0, z));
      rows.push_back(mk(ACT_ACQUIRE, 2, 1000, 200, 8, 0, 0, 0, z));
      rows.push_back(mk(ACT_STOP, 0, 0, 0, 0, 0, 0, 0, z));
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 0, 100, 0, z));
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, z));
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 0, 300, 0, z));
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, z));
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 1, 32'hFFFFFFFF, 0, z));
      rows.push_back(mk(ACT_WRITE, 0, 0, 0, 0, 1, 32'hFFFFFFFE, 0, z));
      rows.push_back(mk(ACT_STOP, 0, 0, 0, 0, 0, 0, 0, z));
      rows.push_back(mk(ACT_ACQUIRE, 3, 5, 1, 1, 0, 0, 0, z));
      rows.push_back(mk(ACT_ACQUIRE, 4, 6, 1, 1, 0, 0, 0, z));
      rows.push_back(mk(ACT_ACQUIRE, 5, 7, 1, 1, 0, 0, 1, blank(ST_NO_TIMER, '0)));
      rows.push_back(mk(ACT_RELEASE, 0, 0, 0, 0, 0, 0, 0, z));
      rows.push_back(mk(ACT_RELEASE, 0, 0, 0, 0, 2, 0, 0, z));
      rows.push_back(mk(ACT_RELEASE, 0, 0, 0, 0, 1, 0, 0, z));

      tx_idle_pct = 24;
      rx_idle_pct = 64;
      foreach (rows[i]) send_item(rows[i].q, rows[i].chk, rows[i].r);

      // random part in three idling phases; mostly legal traffic on few pins
      for (phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 64 : 0;
         rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 24 : 0;
         for (int n = 0; n < 200; n++) begin
            if (phase == 2 && n == 50) hold_req = 1'b1;
            send_item(random_req($urandom_range(9) != 0), 1'b0, z);
         end
      end
      push <= 1'b0;

      // drain, then a settling pause
      wait_count = 0;
      while (pending_results.size() != 0 && wait_count < 200000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (60) @(posedge clock);
      $display("ran %0d items (directed table, then random traffic under three idling mixes)",
               items_sent);
      $display("checked %0d results, including a long receiver hold-off", results_seen);
      if (errors == 0 && pending_results.size() == 0)
         $display("[pwm_channel_timer_allocator_core] OK");
      else
         $display("[pwm_channel_timer_allocator_core] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("[pwm_channel_timer_allocator_core] ERROR");
      $finish;
   end

endmodule
